>>> rtl/core/gwd_pkg.sv
// Shared types, constants and helper functions for the gradient-weighted demosaic.
// Used by gwd_ctrl, gwd_datapath and the top level; depends on nothing else.
package gwd_pkg;

   localparam int MAX_WIDTH    = 4096;
   localparam int SAMPLE_BITS  = 16;
   localparam int COL_BITS     = $clog2(MAX_WIDTH);
   localparam int LS_ADDR_BITS = COL_BITS + 2;
   localparam int LS_DEPTH     = 4 * MAX_WIDTH;
   localparam int PATTERN_BITS = 36;
   localparam int WIDTH_BITS   = 13;
   localparam int HEIGHT_BITS  = 16;
   localparam int ROW_BITS     = 16;
   localparam int WT_BITS      = 13;
   localparam int PROD_BITS    = SAMPLE_BITS + WT_BITS;
   localparam int ACC_BITS     = 34;
   localparam int WSUM_BITS    = 18;
   localparam int MIN_DIM      = 5;

   localparam logic [PATTERN_BITS-1:0] PATTERN_TOP_RESET    = 36'd8666026500;
   localparam logic [PATTERN_BITS-1:0] PATTERN_BOTTOM_RESET = 36'd4433781000;
   localparam logic [WIDTH_BITS-1:0]   WIDTH_RESET          = 13'd1920;
   localparam logic [HEIGHT_BITS-1:0]  HEIGHT_RESET         = 16'd1080;

   localparam logic [WT_BITS-1:0] WROM [5][3] = '{
      '{13'd3724, 13'd7447, 13'd745},
      '{13'd2705, 13'd5410, 13'd541},
      '{13'd1950, 13'd3901, 13'd390},
      '{13'd1753, 13'd3507, 13'd351},
      '{13'd1399, 13'd2797, 13'd280}
   };

   typedef enum logic [1:0] {
      CSR_PATTERN_TOP    = 2'd0,
      CSR_PATTERN_BOTTOM = 2'd1,
      CSR_FRAME_WIDTH    = 2'd2,
      CSR_FRAME_HEIGHT   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      COLOUR_GREEN = 2'd0,
      COLOUR_RED   = 2'd1,
      COLOUR_BLUE  = 2'd2
   } colour_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_COMMIT,
      ST_DECIDE,
      ST_GRAD,
      ST_SUM,
      ST_FLUSH,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_DIV_STORE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   frame_start;
   } req_payload_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] red;
      logic [SAMPLE_BITS-1:0] green;
      logic [SAMPLE_BITS-1:0] blue;
      logic [COL_BITS-1:0]    centre_col;
      logic [ROW_BITS-1:0]    centre_row;
      logic                   frame_end;
   } rsp_payload_type;

   typedef struct packed {
      logic       accept;
      logic       rd_en;
      logic [1:0] rd_line;
      logic       cap_en;
      logic [1:0] cap_slot;
      logic       commit;
      logic       grad_en;
      logic [2:0] grad_dir;
      logic       sum_en;
      logic [2:0] win_row;
      logic [2:0] win_col;
      logic       div_load;
      logic       div_step;
      logic       div_store;
      logic [1:0] div_sel;
      logic       load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic emit;
      logic interior;
   } dp_status_type;

   function automatic int compass_x(input logic [2:0] dir);
      int v;
      case (dir)
         3'd2, 3'd4, 3'd6: v = -1;
         3'd3, 3'd5, 3'd7: v = 1;
         default:          v = 0;
      endcase
      return v;
   endfunction

   function automatic int compass_y(input logic [2:0] dir);
      int v;
      case (dir)
         3'd0, 3'd4, 3'd5: v = -1;
         3'd1, 3'd6, 3'd7: v = 1;
         default:          v = 0;
      endcase
      return v;
   endfunction

   function automatic logic [2:0] mod6(input logic [3:0] v);
      return (v >= 4'd6) ? 3'(v - 4'd6) : v[2:0];
   endfunction

   function automatic colour_type colour_of(input logic [PATTERN_BITS-1:0] top,
                                            input logic [PATTERN_BITS-1:0] bot,
                                            input logic [2:0] xm,
                                            input logic [2:0] ym);
      logic [PATTERN_BITS-1:0] bits;
      logic [2:0]              rr;
      logic [5:0]              idx;
      logic [1:0]              code;
      colour_type              col;
      bits = (ym < 3'd3) ? top : bot;
      rr   = (ym < 3'd3) ? ym : 3'(ym - 3'd3);
      idx  = 6'(2 * (int'(rr) * 6 + int'(xm)));
      code = 2'(bits >> idx);
      case (code)
         2'd0:    col = COLOUR_GREEN;
         2'd1:    col = COLOUR_RED;
         default: col = COLOUR_BLUE;
      endcase
      return col;
   endfunction

   function automatic logic [WT_BITS-1:0] weight_of(input logic [2:0] dir,
                                                    input logic [2:0] rx,
                                                    input logic [2:0] ry);
      int dx, dy, cx, cy, p, n, m, f, cls;
      logic [WT_BITS-1:0] w;
      dx = int'(rx) - 2;
      dy = int'(ry) - 2;
      cx = compass_x(dir);
      cy = compass_y(dir);
      p  = dx * cx + dy * cy;
      n  = dx * dx + dy * dy;
      m  = cx * cx + cy * cy;
      case (n)
         2:       cls = 1;
         4:       cls = 2;
         5:       cls = 3;
         8:       cls = 4;
         default: cls = 0;
      endcase
      if (25 * p * p > 16 * n * m) begin
         f = 1;
      end else if (p == 0) begin
         f = 2;
      end else begin
         f = 0;
      end
      w = (n == 0) ? '0 : WROM[cls][f];
      return w;
   endfunction

endpackage

>>> rtl/core/gwd_ctrl.sv
// Sequencer for the demosaic: input handshake, phase control and result valid.
// Depends on gwd_pkg; drives gwd_datapath through dp_cmd_type.
module gwd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  gwd_pkg::dp_status_type status,
   output gwd_pkg::dp_cmd_type    cmd
);

   gwd_pkg::state_type state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic [2:0] rx_ff, rx_in;
   logic [2:0] ry_ff, ry_in;
   logic [1:0] colour_ff, colour_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_stall = (state_ff != gwd_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gwd_pkg::ST_IDLE: begin
            if (req_valid) state_in = gwd_pkg::ST_READ;
         end
         gwd_pkg::ST_READ: begin
            if (step_ff == 5'd4) state_in = gwd_pkg::ST_COMMIT;
         end
         gwd_pkg::ST_COMMIT: state_in = gwd_pkg::ST_DECIDE;
         gwd_pkg::ST_DECIDE: begin
            if (!status.emit) begin
               state_in = gwd_pkg::ST_IDLE;
            end else if (!status.interior) begin
               state_in = gwd_pkg::ST_DONE;
            end else begin
               state_in = gwd_pkg::ST_GRAD;
            end
         end
         gwd_pkg::ST_GRAD: begin
            if (step_ff == 5'd7) state_in = gwd_pkg::ST_SUM;
         end
         gwd_pkg::ST_SUM: begin
            if (rx_ff == 3'd4 && ry_ff == 3'd4) state_in = gwd_pkg::ST_FLUSH;
         end
         gwd_pkg::ST_FLUSH: state_in = gwd_pkg::ST_DIV_LOAD;
         gwd_pkg::ST_DIV_LOAD: state_in = gwd_pkg::ST_DIV_RUN;
         gwd_pkg::ST_DIV_RUN: begin
            if (step_ff == 5'd15) state_in = gwd_pkg::ST_DIV_STORE;
         end
         gwd_pkg::ST_DIV_STORE: begin
            state_in = (colour_ff == 2'd2) ? gwd_pkg::ST_DONE : gwd_pkg::ST_DIV_LOAD;
         end
         gwd_pkg::ST_DONE: begin
            if (out_free) state_in = gwd_pkg::ST_IDLE;
         end
         default: state_in = gwd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      step_in   = step_ff;
      rx_in     = rx_ff;
      ry_in     = ry_ff;
      colour_in = colour_ff;
      case (state_ff)
         gwd_pkg::ST_IDLE:   step_in = '0;
         gwd_pkg::ST_READ:   step_in = (step_ff == 5'd4) ? '0 : step_ff + 5'd1;
         gwd_pkg::ST_DECIDE: step_in = '0;
         gwd_pkg::ST_GRAD: begin
            step_in = step_ff + 5'd1;
            rx_in   = '0;
            ry_in   = '0;
         end
         gwd_pkg::ST_SUM: begin
            if (rx_ff == 3'd4) begin
               rx_in = '0;
               ry_in = ry_ff + 3'd1;
            end else begin
               rx_in = rx_ff + 3'd1;
            end
         end
         gwd_pkg::ST_FLUSH:    colour_in = '0;
         gwd_pkg::ST_DIV_LOAD: step_in = '0;
         gwd_pkg::ST_DIV_RUN:  step_in = step_ff + 5'd1;
         gwd_pkg::ST_DIV_STORE: colour_in = colour_ff + 2'd1;
         default: step_in = step_ff;
      endcase
   end

   always_comb begin
      cmd          = '0;
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      case (state_ff)
         gwd_pkg::ST_IDLE: cmd.accept = req_valid;
         gwd_pkg::ST_READ: begin
            cmd.rd_en    = (step_ff < 5'd4);
            cmd.rd_line  = step_ff[1:0];
            cmd.cap_en   = (step_ff != 5'd0);
            cmd.cap_slot = 2'(step_ff - 5'd1);
         end
         gwd_pkg::ST_COMMIT: cmd.commit = 1'b1;
         gwd_pkg::ST_GRAD: begin
            cmd.grad_en  = 1'b1;
            cmd.grad_dir = step_ff[2:0];
            cmd.win_row  = 3'(2 + 2 * gwd_pkg::compass_y(step_ff[2:0]));
            cmd.win_col  = 3'(2 + 2 * gwd_pkg::compass_x(step_ff[2:0]));
         end
         gwd_pkg::ST_SUM: begin
            cmd.sum_en  = 1'b1;
            cmd.win_row = ry_ff;
            cmd.win_col = rx_ff;
         end
         gwd_pkg::ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            cmd.div_sel  = colour_ff;
         end
         gwd_pkg::ST_DIV_RUN: cmd.div_step = 1'b1;
         gwd_pkg::ST_DIV_STORE: begin
            cmd.div_store = 1'b1;
            cmd.div_sel   = colour_ff;
         end
         gwd_pkg::ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gwd_pkg::ST_IDLE;
         step_ff      <= '0;
         rx_ff        <= '0;
         ry_ff        <= '0;
         colour_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rx_ff        <= rx_in;
         ry_ff        <= ry_in;
         colour_ff    <= colour_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == gwd_pkg::ST_READ))
      else $error("accepted item did not start the line store read");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gwd_pkg::ST_DONE && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("finished item not loaded into the empty result register");

   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gwd_pkg::ST_SUM) |-> (rx_ff <= 3'd4 && ry_ff <= 3'd4))
      else $error("window step outside the 5x5 window");
`endif

endmodule

>>> rtl/core/gwd_datapath.sv
// Datapath for the demosaic: registers, line store, window, gradient,
// weighted sums, bit-serial divider and result register. Depends on gwd_pkg.
module gwd_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  gwd_pkg::csr_index_type               csr_index,
   input  logic [gwd_pkg::PATTERN_BITS-1:0]     csr_data,
   input  gwd_pkg::req_payload_type             req_payload,
   input  gwd_pkg::dp_cmd_type                  cmd,
   output gwd_pkg::dp_status_type               status,
   output gwd_pkg::rsp_payload_type             rsp_payload
);

   localparam int SB = gwd_pkg::SAMPLE_BITS;
   localparam int CB = gwd_pkg::COL_BITS;
   localparam int RB = gwd_pkg::ROW_BITS;
   localparam int WB = gwd_pkg::WIDTH_BITS;
   localparam int HB = gwd_pkg::HEIGHT_BITS;

   logic [gwd_pkg::PATTERN_BITS-1:0] top_ff, bot_ff;
   logic [WB-1:0]                    width_ff;
   logic [HB-1:0]                    height_ff;

   logic [CB-1:0] col_ff, col_in;
   logic [RB-1:0] row_ff, row_in;
   logic [2:0]    cm_ff, cm_in, rm_ff, rm_in;

   logic [SB-1:0] sample_ff;
   logic [CB-1:0] c_ff, cur_c;
   logic [RB-1:0] r_ff, cur_r;
   logic [2:0]    cmod_ff, cur_cm, rmod_ff, cur_rm;

   logic [SB-1:0] line_mem [gwd_pkg::LS_DEPTH];
   logic [SB-1:0] rd_data_ff;
   logic [SB-1:0] colbuf_ff [4];
   logic [SB-1:0] win_ff [5][5];
   logic [SB-1:0] win_rd, ctr, grad;

   logic [CB-1:0]    cc_ff;
   logic [RB-1:0]    cr_ff;
   logic             fe_ff, emit_ff, interior_ff;
   gwd_pkg::colour_type ctype_ff;

   logic [SB-1:0] min_ff;
   logic [2:0]    best_ff;

   logic [gwd_pkg::PROD_BITS-1:0] prod_ff;
   logic [gwd_pkg::WT_BITS-1:0]   pw_ff, wt;
   gwd_pkg::colour_type           pt_ff, nt;
   logic                          pv_ff;
   logic [gwd_pkg::ACC_BITS-1:0]  sum_ff [3];
   logic [gwd_pkg::WSUM_BITS-1:0] wsum_ff [3];

   logic [gwd_pkg::WSUM_BITS-1:0] rem_ff, dvs_ff;
   logic [SB-1:0]                 quo_ff;
   logic [gwd_pkg::WSUM_BITS:0]   rem_sh;
   logic [SB-1:0]                 res_ff [3];

   gwd_pkg::rsp_payload_type out_ff;

   logic [WB-1:0] wc;
   logic [HB-1:0] hc;
   logic [WB-1:0] c0, c1, cn;
   logic [RB:0]   r0, r1, r2, rn;
   logic [2:0]    cm0, rm0, rm1;

   always_comb begin
      if (width_ff < WB'(gwd_pkg::MIN_DIM)) begin
         wc = WB'(gwd_pkg::MIN_DIM);
      end else if (width_ff > WB'(gwd_pkg::MAX_WIDTH)) begin
         wc = WB'(gwd_pkg::MAX_WIDTH);
      end else begin
         wc = width_ff;
      end
      hc = (height_ff < HB'(gwd_pkg::MIN_DIM)) ? HB'(gwd_pkg::MIN_DIM) : height_ff;
   end

   always_comb begin
      c0  = req_payload.frame_start ? '0 : {1'b0, col_ff};
      r0  = req_payload.frame_start ? '0 : {1'b0, row_ff};
      cm0 = req_payload.frame_start ? '0 : cm_ff;
      rm0 = req_payload.frame_start ? '0 : rm_ff;
      if (c0 >= wc) begin
         c1     = '0;
         r1     = r0 + 1'b1;
         rm1    = (rm0 == 3'd5) ? '0 : rm0 + 3'd1;
         cur_cm = '0;
      end else begin
         c1     = c0;
         r1     = r0;
         rm1    = rm0;
         cur_cm = cm0;
      end
      if (r1 >= {1'b0, hc}) begin
         r2     = '0;
         cur_rm = '0;
      end else begin
         r2     = r1;
         cur_rm = rm1;
      end
      cur_c = c1[CB-1:0];
      cur_r = r2[RB-1:0];
      cn    = {1'b0, cur_c} + 1'b1;
      rn    = {1'b0, cur_r} + 1'b1;
      if (cn >= wc) begin
         col_in = '0;
         cm_in  = '0;
         if (rn >= {1'b0, hc}) begin
            row_in = '0;
            rm_in  = '0;
         end else begin
            row_in = rn[RB-1:0];
            rm_in  = (cur_rm == 3'd5) ? '0 : cur_rm + 3'd1;
         end
      end else begin
         col_in = cn[CB-1:0];
         cm_in  = (cur_cm == 3'd5) ? '0 : cur_cm + 3'd1;
         row_in = cur_r;
         rm_in  = cur_rm;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff    <= gwd_pkg::PATTERN_TOP_RESET;
         bot_ff    <= gwd_pkg::PATTERN_BOTTOM_RESET;
         width_ff  <= gwd_pkg::WIDTH_RESET;
         height_ff <= gwd_pkg::HEIGHT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            gwd_pkg::CSR_PATTERN_TOP:    top_ff    <= csr_data;
            gwd_pkg::CSR_PATTERN_BOTTOM: bot_ff    <= csr_data;
            gwd_pkg::CSR_FRAME_WIDTH:    width_ff  <= csr_data[WB-1:0];
            gwd_pkg::CSR_FRAME_HEIGHT:   height_ff <= csr_data[HB-1:0];
            default:                     top_ff    <= top_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         cm_ff  <= '0;
         rm_ff  <= '0;
      end else if (cmd.accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
         cm_ff  <= cm_in;
         rm_ff  <= rm_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_payload.sample;
         c_ff      <= cur_c;
         r_ff      <= cur_r;
         cmod_ff   <= cur_cm;
         rmod_ff   <= cur_rm;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= line_mem[{2'(r_ff[1:0] + cmd.rd_line), c_ff}];
      end
      if (cmd.commit) begin
         line_mem[{r_ff[1:0], c_ff}] <= sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_en) begin
         colbuf_ff[cmd.cap_slot] <= rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 5; i++) begin
            for (int j = 0; j < 5; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (cmd.commit) begin
         for (int i = 0; i < 5; i++) begin
            for (int j = 0; j < 4; j++) begin
               win_ff[i][j] <= win_ff[i][j+1];
            end
         end
         for (int i = 0; i < 4; i++) begin
            win_ff[i][4] <= colbuf_ff[i];
         end
         win_ff[4][4] <= sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_ff     <= 1'b0;
         interior_ff <= 1'b0;
      end else if (cmd.commit) begin
         emit_ff     <= !(r_ff < RB'(2) || (r_ff == RB'(2) && c_ff < CB'(2)));
         interior_ff <= (c_ff >= CB'(4)) && (r_ff >= RB'(4));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (c_ff >= CB'(2)) begin
            cc_ff <= c_ff - CB'(2);
            cr_ff <= r_ff - RB'(2);
         end else begin
            cc_ff <= CB'(wc - WB'(2) + {1'b0, c_ff});
            cr_ff <= r_ff - RB'(3);
         end
         fe_ff    <= ({1'b0, c_ff} == wc - WB'(1)) && (r_ff == hc - HB'(1));
         ctype_ff <= gwd_pkg::colour_of(top_ff, bot_ff,
                        gwd_pkg::mod6({1'b0, cmod_ff} + 4'd4),
                        gwd_pkg::mod6({1'b0, rmod_ff} + 4'd4));
      end
   end

   assign status.emit     = emit_ff;
   assign status.interior = interior_ff;

   assign win_rd = win_ff[cmd.win_row][cmd.win_col];
   assign ctr    = win_ff[2][2];
   assign grad   = (ctr > win_rd) ? ctr - win_rd : win_rd - ctr;

   always_ff @(posedge clock) begin
      if (cmd.grad_en) begin
         if (cmd.grad_dir == 3'd0 || grad < min_ff) begin
            min_ff  <= grad;
            best_ff <= cmd.grad_dir;
         end
      end
   end

   assign wt = gwd_pkg::weight_of(best_ff, cmd.win_col, cmd.win_row);
   assign nt = gwd_pkg::colour_of(top_ff, bot_ff,
                  gwd_pkg::mod6({1'b0, cmod_ff} + {1'b0, cmd.win_col} + 4'd2),
                  gwd_pkg::mod6({1'b0, rmod_ff} + {1'b0, cmd.win_row} + 4'd2));

   always_ff @(posedge clock) begin
      if (cmd.sum_en) begin
         prod_ff <= win_rd * wt;
         pw_ff   <= wt;
         pt_ff   <= nt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= cmd.sum_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         for (int t = 0; t < 3; t++) begin
            sum_ff[t]  <= '0;
            wsum_ff[t] <= '0;
         end
      end else if (pv_ff) begin
         sum_ff[pt_ff]  <= sum_ff[pt_ff] + gwd_pkg::ACC_BITS'(prod_ff);
         wsum_ff[pt_ff] <= wsum_ff[pt_ff] + gwd_pkg::WSUM_BITS'(pw_ff);
      end
   end

   assign rem_sh = {rem_ff, quo_ff[SB-1]};

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff <= sum_ff[cmd.div_sel][gwd_pkg::ACC_BITS-1:SB];
         quo_ff <= sum_ff[cmd.div_sel][SB-1:0];
         dvs_ff <= wsum_ff[cmd.div_sel];
      end else if (cmd.div_step) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_ff <= gwd_pkg::WSUM_BITS'(rem_sh - {1'b0, dvs_ff});
            quo_ff <= {quo_ff[SB-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[gwd_pkg::WSUM_BITS-1:0];
            quo_ff <= {quo_ff[SB-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_store) begin
         res_ff[cmd.div_sel] <= (dvs_ff == '0) ? '0 : quo_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_ff.centre_col <= cc_ff;
         out_ff.centre_row <= cr_ff;
         out_ff.frame_end  <= fe_ff;
         if (interior_ff) begin
            out_ff.red   <= (ctype_ff == gwd_pkg::COLOUR_RED)   ? ctr : res_ff[1];
            out_ff.green <= (ctype_ff == gwd_pkg::COLOUR_GREEN) ? ctr : res_ff[0];
            out_ff.blue  <= (ctype_ff == gwd_pkg::COLOUR_BLUE)  ? ctr : res_ff[2];
         end else begin
            out_ff.red   <= '0;
            out_ff.green <= '0;
            out_ff.blue  <= '0;
         end
      end
   end

   assign rsp_payload = out_ff;

endmodule

>>> rtl/core/cfa6x6_gradient_weighted_demosaic_unit.sv
// Items are taken one at a time. An interior pixel runs the line store read,
// commit, decision, gradient search, a 25-step weighted sum and three 16-step
// bit-serial divisions before its result; a border pixel goes from the decision
// to the result, and an item with no result frees the input after the decision.
// Reset (synchronous, active high) restores the register defaults, clears the
// window and position counters; the line store is not cleared.
module cfa6x6_gradient_weighted_demosaic_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  gwd_pkg::req_payload_type         req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output gwd_pkg::rsp_payload_type         rsp_payload,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  gwd_pkg::csr_index_type           csr_index,
   input  logic [gwd_pkg::PATTERN_BITS-1:0] csr_data
);

   gwd_pkg::dp_cmd_type    cmd;
   gwd_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   gwd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   gwd_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule
